// ----- hw/rtl/tone_rate_pitch_mapper_defines.svh -----
// ----------------------------------------------------------------------------
// Tone rate and pitch mapper assertion macros
// Assertion wrappers shared by the mapper RTL. Define ASSERT_OFF to drop them.
// ----------------------------------------------------------------------------
`ifndef TONE_RATE_PITCH_MAPPER_DEFINES_SVH
`define TONE_RATE_PITCH_MAPPER_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked property, quiet while reset is asserted.
`define TRPM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("tone_rate_pitch_mapper assertion failed");
// Checked property that also holds during reset.
`define TRPM_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("tone_rate_pitch_mapper assertion failed");
`else
`define TRPM_ASSERT(lbl, prop)
`define TRPM_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ----- hw/rtl/trpm_pkg.sv -----
// ----------------------------------------------------------------------------
// Tone rate and pitch mapper package
// Constants, codes and the request/response types of the shared unit.
// ----------------------------------------------------------------------------
`default_nettype none

package trpm_pkg;

    localparam int DIV_STEPS = 16;
    localparam int MD_CNT_W  = $clog2(DIV_STEPS + 1);

    localparam logic [10:0] PITCH_LOW  = 11'd220;
    localparam logic [10:0] PITCH_HIGH = 11'd1760;
    localparam logic [10:0] PITCH_SPAN = 11'd1540;
    localparam logic signed [11:0] CHIRP_UP   = 12'sd1540;
    localparam logic signed [11:0] CHIRP_DOWN = -12'sd1540;

    localparam logic [31:0] INVALID_MARK = 32'h7FFF_FFFF;

    // Operation codes of an input word.
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_MUTE   = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    // Register indexes.
    localparam logic [2:0] CFG_FLAT_EN   = 3'd0;
    localparam logic [2:0] CFG_FLAT_RATE = 3'd1;
    localparam logic [2:0] CFG_RATE_MIN  = 3'd2;
    localparam logic [2:0] CFG_RATE_MAX  = 3'd3;
    localparam logic [2:0] CFG_LIMIT     = 3'd4;

    // Limit modes.
    localparam logic [1:0] LIM_MUTE  = 2'd0;
    localparam logic [1:0] LIM_CLAMP = 2'd1;
    localparam logic [1:0] LIM_CHIRP = 2'd2;
    localparam logic [1:0] LIM_REV   = 2'd3;

    typedef struct packed {
        logic        start;
        logic [15:0] mul_a;
        logic [31:0] mul_b;
        logic [31:0] div_d;
    } t_md_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [15:0] quo;
        logic [31:0] rem;
    } t_md_rsp;

endpackage

`default_nettype wire

// ----- hw/rtl/trpm_muldiv.sv -----
// ----------------------------------------------------------------------------
// Shared multiply and divide unit
// One 16x32 multiply into a 48-bit numerator, then a restoring divide by a
// 32-bit divisor at one quotient bit per cycle, sixteen bits in all.
// ----------------------------------------------------------------------------
`default_nettype none

module trpm_muldiv (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  trpm_pkg::t_md_req i_req,
    output trpm_pkg::t_md_rsp o_rsp
);
    import trpm_pkg::*;

    logic [31:0]         r_hi;
    logic [15:0]         r_lo;
    logic [31:0]         r_d;
    logic [MD_CNT_W-1:0] r_cnt;
    logic                r_busy;
    logic                r_done;

    logic [47:0] w_prod;
    logic [32:0] w_shift;
    logic [33:0] w_diff;
    logic        w_take;

    assign w_prod  = 48'(i_req.mul_a) * 48'(i_req.mul_b);
    assign w_shift = {r_hi, r_lo[15]};
    assign w_diff  = {1'b0, w_shift} - {2'b00, r_d};
    assign w_take  = ~w_diff[33];

    // The caller guarantees that the quotient fits in sixteen bits, so the
    // upper numerator bits start out below the divisor.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_req.start && (r_cnt == MD_CNT_W'(1));
            if (i_req.start) begin
                {r_hi, r_lo} <= w_prod;
                r_d          <= i_req.div_d;
                r_cnt        <= MD_CNT_W'(DIV_STEPS);
                r_busy       <= 1'b1;
            end else if (r_busy) begin
                r_hi  <= w_take ? w_diff[31:0] : w_shift[31:0];
                r_lo  <= {r_lo[14:0], w_take};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == MD_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_lo;
    assign o_rsp.rem  = r_hi;

endmodule

`default_nettype wire

// ----- hw/rtl/tone_rate_pitch_mapper.sv -----
// ----------------------------------------------------------------------------
// Tone rate and pitch mapper
// Maps two metrics onto a beep rate, pitch and chirp and runs the beep phase.
// ----------------------------------------------------------------------------
// A sample word passes from acceptance to its result word through a setup
// state, then two passes through the shared multiply/divide unit (a start
// state, sixteen divide steps, then the quotient handed back) for the rate
// and then the pitch, with the tone state updated as the pitch quotient comes
// back, and a final state that loads the output register. Mute and tick words
// pass through one apply state before that load. The block takes one word at
// a time and holds o_in_stall high until the result is in the output register,
// which a stalled result word delays. The user must write registers through the
// configuration port only while idle; the block itself does not enforce this.
`default_nettype none
`include "tone_rate_pitch_mapper_defines.svh"

module tone_rate_pitch_mapper (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic signed [31:0] i_value_one,
    input  logic signed [31:0] i_lower_one,
    input  logic signed [31:0] i_upper_one,
    input  logic signed [31:0] i_value_two,
    input  logic signed [31:0] i_lower_two,
    input  logic signed [31:0] i_upper_two,
    input  logic        i_audio_idle,
    input  logic        i_speech_playing,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_beep,
    output logic [10:0] o_beep_start_hz,
    output logic [10:0] o_beep_end_hz,
    output logic [15:0] o_tone_rate
);
    import trpm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_PREP, ST_RATE, ST_RWAIT, ST_PITCH, ST_PWAIT, ST_APPLY, ST_FIN
    } t_state;

    t_state r_state;

    // Configuration.
    logic        r_flat_en;
    logic [15:0] r_flat_rate;
    logic [15:0] r_rate_min;
    logic [15:0] r_rate_max;
    logic [1:0]  r_limit;

    // Tone state.
    logic [15:0]        r_rate;
    logic [10:0]        r_pitch;
    logic signed [11:0] r_chirp;
    logic [15:0]        r_phase;
    logic               r_beep;

    // Captured input word.
    logic [1:0]         r_op;
    logic signed [31:0] r_v1, r_l1, r_u1, r_v2, r_l2, r_u2;
    logic               r_idle, r_speech;

    // Setup results.
    logic        r_invalid;
    logic        r_under1, r_over1, r_under2, r_over2;
    logic [31:0] r_dv1, r_dd1, r_dv2, r_dd2;
    logic        r_span_neg;
    logic [15:0] r_span_abs;
    logic [15:0] r_rate_q;

    logic        r_out_valid;
    logic [10:0] r_out_start;
    logic [10:0] r_out_end;
    logic [15:0] r_out_rate;
    logic        r_out_beep;

    t_md_req w_md_req;
    t_md_rsp w_md_rsp;

    logic signed [32:0] w_dv1, w_dd1, w_dv2, w_dd2;
    logic [16:0]        w_span;
    logic [16:0]        w_phase_sum;
    logic               w_round;
    logic [10:0]        w_pitch_in;
    logic [15:0]        w_rate_in;
    logic [15:0]        w_rate_map;
    logic [11:0]        w_end_sum;
    logic               w_out_free;

    trpm_muldiv u_md (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_md_req),
        .o_rsp   (w_md_rsp)
    );

    assign w_dv1 = {r_v1[31], r_v1} - {r_l1[31], r_l1};
    assign w_dd1 = {r_u1[31], r_u1} - {r_l1[31], r_l1};
    assign w_dv2 = {r_v2[31], r_v2} - {r_l2[31], r_l2};
    assign w_dd2 = {r_u2[31], r_u2} - {r_l2[31], r_l2};
    assign w_span = {1'b0, r_rate_max} - {1'b0, r_rate_min};

    always_comb begin
        w_md_req.start = (r_state == ST_RATE) || (r_state == ST_PITCH);
        if (r_state == ST_PITCH) begin
            w_md_req.mul_a = 16'(PITCH_SPAN);
            w_md_req.mul_b = r_dv1;
            w_md_req.div_d = r_dd1;
        end else begin
            w_md_req.mul_a = r_span_abs;
            w_md_req.mul_b = r_dv2;
            w_md_req.div_d = r_dd2;
        end
    end

    // Round half up: add one when twice the remainder reaches the divisor.
    assign w_round    = {w_md_rsp.rem, 1'b0} >= {1'b0, r_dd1};
    assign w_pitch_in = PITCH_LOW + w_md_rsp.quo[10:0] + 11'(w_round);
    assign w_rate_in  = r_span_neg ? (r_rate_min - r_rate_q) : (r_rate_min + r_rate_q);

    always_comb begin
        if (r_under2) begin
            w_rate_map = r_flat_en ? r_flat_rate : r_rate_min;
        end else if (r_over2) begin
            w_rate_map = r_rate_max - 16'd1;
        end else begin
            w_rate_map = w_rate_in;
        end
    end

    // The phase wraps exactly when 65536 - phase <= rate.
    assign w_phase_sum = {1'b0, r_phase} + {1'b0, r_rate};
    assign w_end_sum   = $signed({1'b0, r_pitch}) + r_chirp;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flat_en   <= 1'b0;
            r_flat_rate <= 16'd0;
            r_rate_min  <= 16'd0;
            r_rate_max  <= 16'hFFFF;
            r_limit     <= LIM_CLAMP;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FLAT_EN:   r_flat_en   <= i_cfg_data[0];
                CFG_FLAT_RATE: r_flat_rate <= i_cfg_data;
                CFG_RATE_MIN:  r_rate_min  <= i_cfg_data;
                CFG_RATE_MAX:  r_rate_max  <= i_cfg_data;
                CFG_LIMIT:     r_limit     <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rate      <= 16'd0;
            r_pitch     <= 11'd0;
            r_chirp     <= 12'sd0;
            r_phase     <= 16'd0;
            r_beep      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state != ST_FIN) && r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_op     <= i_op;
                        r_v1     <= i_value_one;
                        r_l1     <= i_lower_one;
                        r_u1     <= i_upper_one;
                        r_v2     <= i_value_two;
                        r_l2     <= i_lower_two;
                        r_u2     <= i_upper_two;
                        r_idle   <= i_audio_idle;
                        r_speech <= i_speech_playing;
                        r_state  <= (i_op == OP_SAMPLE) ? ST_PREP : ST_APPLY;
                    end
                end
                ST_PREP: begin
                    r_invalid  <= (r_v1 == INVALID_MARK) || (r_v2 == INVALID_MARK);
                    r_under1   <= (r_l1 < r_u1) ? (r_v1 <= r_l1) : (r_v1 >= r_l1);
                    r_over1    <= (r_l1 < r_u1) ? (r_v1 >= r_u1) : (r_v1 <= r_u1);
                    r_under2   <= (r_l2 < r_u2) ? (r_v2 <= r_l2) : (r_v2 >= r_l2);
                    r_over2    <= (r_l2 < r_u2) ? (r_v2 >= r_u2) : (r_v2 <= r_u2);
                    r_dv1      <= w_dv1[32] ? 32'(-w_dv1) : w_dv1[31:0];
                    r_dd1      <= w_dd1[32] ? 32'(-w_dd1) : w_dd1[31:0];
                    r_dv2      <= w_dv2[32] ? 32'(-w_dv2) : w_dv2[31:0];
                    r_dd2      <= w_dd2[32] ? 32'(-w_dd2) : w_dd2[31:0];
                    r_span_neg <= w_span[16];
                    r_span_abs <= w_span[16] ? 16'(-w_span) : w_span[15:0];
                    r_state    <= ST_RATE;
                end
                ST_RATE: begin
                    r_state <= ST_RWAIT;
                end
                ST_RWAIT: begin
                    if (w_md_rsp.done) begin
                        r_rate_q <= w_md_rsp.quo;
                        r_state  <= ST_PITCH;
                    end
                end
                ST_PITCH: begin
                    r_state <= ST_PWAIT;
                end
                ST_PWAIT: begin
                    // The pitch quotient is used here, on the cycle it appears.
                    if (w_md_rsp.done) begin
                        r_beep <= 1'b0;
                        // Muting on an out-of-range pitch metric overrides the rate.
                        if (r_invalid || ((r_under1 || r_over1) && (r_limit == LIM_MUTE))) begin
                            r_rate <= 16'd0;
                        end else begin
                            r_rate <= w_rate_map;
                        end
                        if (!r_invalid) begin
                            if (r_under1 || r_over1) begin
                                case (r_limit)
                                    LIM_MUTE: ;
                                    LIM_CLAMP: begin
                                        r_pitch <= r_under1 ? PITCH_LOW : PITCH_HIGH;
                                        r_chirp <= 12'sd0;
                                    end
                                    LIM_CHIRP: begin
                                        r_pitch <= r_under1 ? PITCH_LOW : PITCH_HIGH;
                                        r_chirp <= r_under1 ? CHIRP_UP : CHIRP_DOWN;
                                    end
                                    default: begin
                                        r_pitch <= r_under1 ? PITCH_HIGH : PITCH_LOW;
                                        r_chirp <= r_under1 ? CHIRP_DOWN : CHIRP_UP;
                                    end
                                endcase
                            end else begin
                                r_pitch <= w_pitch_in;
                                r_chirp <= 12'sd0;
                            end
                        end
                        r_state <= ST_FIN;
                    end
                end
                ST_APPLY: begin
                    r_beep <= (r_op == OP_TICK) && r_idle && !r_speech
                              && (r_rate != 16'd0) && w_phase_sum[16];
                    case (r_op)
                        OP_MUTE: begin
                            r_rate <= 16'd0;
                        end
                        OP_TICK: begin
                            r_phase <= w_phase_sum[15:0];
                        end
                        default: ;
                    endcase
                    r_state <= ST_FIN;
                end
                ST_FIN: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_beep  <= r_beep;
                        r_out_start <= r_pitch;
                        r_out_end   <= w_end_sum[10:0];
                        r_out_rate  <= r_rate;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_cfg_ready     = 1'b1;
    assign o_in_stall      = (r_state != ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_beep          = r_out_beep;
    assign o_beep_start_hz = r_out_start;
    assign o_beep_end_hz   = r_out_end;
    assign o_tone_rate     = r_out_rate;

    `TRPM_ASSERT(a_beep_needs_rate, (o_out_valid && o_beep) |-> (o_tone_rate != 16'd0))
    `TRPM_ASSERT(a_accept_unit_idle, (i_in_valid && !o_in_stall) |-> !w_md_rsp.busy)
    `TRPM_ASSERT(a_done_when_waiting, w_md_rsp.done |-> (r_state inside {ST_RWAIT, ST_PWAIT}))
    `TRPM_ASSERT_ALWAYS(a_start_in_range, o_out_valid |-> (o_beep_start_hz <= PITCH_HIGH))

endmodule

`default_nettype wire
